FILE: sv/nta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and codes of the neighbor table with aging.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;
  localparam int IFACE_W    = 2;
  localparam int WORD_W     = 32;
  localparam int AGE_W      = 8;
  localparam int CNT_OUT_W  = 5;

  localparam logic [AGE_W-1:0] DEAD_LIMIT_RST = 8'd15;
  localparam logic [AGE_W-1:0] AGE_MAX        = 8'hFF;

  typedef enum logic {
    OP_HELLO = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUT_REFRESH = 2'd0,
    OUT_ADDED   = 2'd1,
    OUT_DROPPED = 2'd2,
    OUT_TICK    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  addr;
    logic [WORD_W-1:0]  id;
    logic [IFACE_W-1:0] iface;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/neighbor_table_with_aging_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top
// Per-interface neighbor table: hello lookup and insert, tick-driven aging.
//
// Usage:
//   s_axis carries one request: tuser = operation (hello or tick), tdata =
//   interface, router id, source address, mask. m_axis returns one result
//   per request: tuser = outcome, tdata = interface count, removed count,
//   update request. cfg_we_i/cfg_wdata_i write the dead limit; the user
//   must write it only while idle, the block does not enforce this.
//   One request is in work at a time. A hello or a tick walks all
//   MAX_NEIGHBORS entries of the table memory, one read a cycle; a hello
//   then passes an update state, and a hello on an interface beyond
//   NUM_IFACES skips the walk. The next request is taken once its result
//   has moved into the output register. Reset clears all valid bits, the
//   interface counts and the output register, and loads the dead limit
//   with 15; the table takes requests as soon as reset is released.
//   A result waits in the output register while the receiver stalls; the
//   next request is still accepted and worked on, and its result waits
//   until the register is free.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int NUM_IFACES    = 4
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [nta_pkg::AGE_W-1:0]          cfg_wdata_i,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] iface_index, [33:2] neighbor_id, [65:34] neighbor_addr,
  // [97:66] neighbor_mask, rest zero
  input  wire [nta_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] operation
  input  wire [0:0]                         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // [4:0] iface_count, [9:5] removed_count, [10] update_request, rest zero
  output logic [nta_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [1:0] outcome
  output logic [1:0]                        m_axis_tuser_o
);
  import nta_pkg::*;

  localparam int AW  = $clog2(MAX_NEIGHBORS);
  localparam int SW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int CIW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

  function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [SW-1:0] v);
    return (32'(v) > 32'd31) ? 5'd31 : CNT_OUT_W'(v);
  endfunction

  // memories
  entry_t           ent_mem [MAX_NEIGHBORS];
  logic [AGE_W-1:0] age_mem [MAX_NEIGHBORS];
  entry_t           ent_rd_q;
  logic [AGE_W-1:0] age_rd_q;

  state_e state_q, state_d;

  logic [AGE_W-1:0]   dead_limit_q;
  logic               op_q;
  logic [IFACE_W-1:0] ifc_q;
  logic [WORD_W-1:0]  id_q, addr_q, mask_q;

  logic [SW-1:0]  scan_q;
  logic           chk_vld_q;
  logic [AW-1:0]  chk_idx_q;
  logic           hit_q, free_q;
  logic [AW-1:0]  hit_idx_q, free_idx_q;
  logic [SW-1:0]  rem_q;

  logic [MAX_NEIGHBORS-1:0] valid_q;
  logic [SW-1:0]            cnt_q [NUM_IFACES];

  logic [1:0]           res_outcome_q;
  logic [CNT_OUT_W-1:0] res_count_q;
  logic [CNT_OUT_W-1:0] res_removed_q;
  logic                 res_upd_q;

  logic                 m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [1:0]           m_user_q;

  logic               accept;
  logic               issue;
  logic [AW-1:0]      rd_addr;
  logic               iface_ok;
  logic               chk_hello;
  logic               chk_tick;
  logic [AGE_W-1:0]   age_inc;
  logic               age_dead;
  logic [CIW-1:0]     cnt_idx;
  logic [SW-1:0]      cnt_rd;
  logic               out_free;

  logic               age_we;
  logic [AW-1:0]      age_waddr;
  logic [AGE_W-1:0]   age_wdata;
  logic               ent_we;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign iface_ok        = ({30'd0, s_axis_tdata_i[1:0]} < 32'(NUM_IFACES));
  assign issue           = (state_q == ST_SCAN) && (32'(scan_q) < 32'(MAX_NEIGHBORS));
  assign rd_addr         = scan_q[AW-1:0];
  assign chk_hello       = chk_vld_q && (op_q == OP_HELLO);
  assign chk_tick        = chk_vld_q && (op_q == OP_TICK) && valid_q[chk_idx_q];
  assign age_inc         = (age_rd_q == AGE_MAX) ? AGE_MAX : age_rd_q + 8'd1;
  assign age_dead        = (age_inc >= dead_limit_q);
  assign cnt_idx         = (state_q == ST_SCAN) ? CIW'(ent_rd_q.iface) : CIW'(ifc_q);
  assign cnt_rd          = cnt_q[cnt_idx];
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    age_we    = 1'b0;
    age_waddr = chk_idx_q;
    age_wdata = age_inc;
    ent_we    = 1'b0;
    if (chk_tick && !age_dead) begin
      age_we = 1'b1;
    end else if (state_q == ST_UPDATE && (hit_q || free_q)) begin
      age_we    = 1'b1;
      age_waddr = hit_q ? hit_idx_q : free_idx_q;
      age_wdata = '0;
      ent_we    = !hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ent_rd_q <= ent_mem[rd_addr];
      age_rd_q <= age_mem[rd_addr];
    end
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (ent_we) begin
      ent_mem[free_idx_q] <= '{mask: mask_q, addr: addr_q, id: id_q, iface: ifc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i[0] == OP_TICK || iface_ok) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (!issue && !chk_vld_q) begin
          state_d = (op_q == OP_TICK) ? ST_FINISH : ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_limit_q  <= DEAD_LIMIT_RST;
      op_q          <= OP_HELLO;
      scan_q        <= '0;
      chk_vld_q     <= 1'b0;
      chk_idx_q     <= '0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      hit_idx_q     <= '0;
      free_idx_q    <= '0;
      rem_q         <= '0;
      valid_q       <= '0;
      res_outcome_q <= OUT_DROPPED;
      res_count_q   <= '0;
      res_removed_q <= '0;
      res_upd_q     <= 1'b0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= '0;
      for (int i = 0; i < NUM_IFACES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        dead_limit_q <= cfg_wdata_i;
      end

      if (accept) begin
        op_q   <= s_axis_tuser_i[0];
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        rem_q  <= '0;
        if (s_axis_tuser_i[0] == OP_HELLO && !iface_ok) begin
          res_outcome_q <= OUT_DROPPED;
          res_count_q   <= '0;
          res_removed_q <= '0;
          res_upd_q     <= 1'b0;
        end
      end

      if (issue) begin
        scan_q <= scan_q + 1'b1;
      end
      chk_vld_q <= issue;
      chk_idx_q <= rd_addr;

      // hello lookup: first matching entry, lowest free slot
      if (chk_hello) begin
        if (valid_q[chk_idx_q]) begin
          if (!hit_q && ent_rd_q.iface == ifc_q && ent_rd_q.id == id_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= chk_idx_q;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
      end

      // aging and removal
      if (chk_tick && age_dead) begin
        valid_q[chk_idx_q] <= 1'b0;
        rem_q              <= rem_q + 1'b1;
        if (cnt_rd != '0) begin
          cnt_q[cnt_idx] <= cnt_rd - 1'b1;
        end
      end

      if (state_q == ST_SCAN && state_d == ST_FINISH) begin
        res_outcome_q <= OUT_TICK;
        res_count_q   <= '0;
        res_removed_q <= sat_cnt(rem_q);
        res_upd_q     <= 1'b0;
      end

      if (state_q == ST_UPDATE) begin
        res_removed_q <= '0;
        if (hit_q) begin
          res_outcome_q <= OUT_REFRESH;
          res_count_q   <= sat_cnt(cnt_rd);
          res_upd_q     <= 1'b0;
        end else if (free_q) begin
          res_outcome_q       <= OUT_ADDED;
          res_upd_q           <= 1'b1;
          res_count_q         <= sat_cnt(cnt_rd + 1'b1);
          valid_q[free_idx_q] <= 1'b1;
          cnt_q[cnt_idx]      <= cnt_rd + 1'b1;
        end else begin
          res_outcome_q <= OUT_DROPPED;
          res_count_q   <= sat_cnt(cnt_rd);
          res_upd_q     <= 1'b0;
        end
      end

      if (state_q == ST_FINISH && out_free) begin
        m_valid_q <= 1'b1;
        m_user_q  <= res_outcome_q;
        m_data_q  <= {5'd0, res_upd_q, res_removed_q, res_count_q};
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ifc_q  <= s_axis_tdata_i[1:0];
      id_q   <= s_axis_tdata_i[33:2];
      addr_q <= s_axis_tdata_i[65:34];
      mask_q <= s_axis_tdata_i[97:66];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

FILE: sv/nta_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_chk
// Port-level checks of the neighbor table results.
// ----------------------------------------------------------------------------
module nta_chk (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            m_axis_tvalid_o,
  input wire                            m_axis_tready_i,
  input wire [nta_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input wire [1:0]                      m_axis_tuser_o
);
  import nta_pkg::*;

  a_tick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == OUT_TICK |->
      m_axis_tdata_o[4:0] == 5'd0 && !m_axis_tdata_o[10])
    else $error("tick result carries hello fields");

  a_hello_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != OUT_TICK |-> m_axis_tdata_o[9:5] == 5'd0)
    else $error("hello result carries a removed count");

  a_update_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |->
      m_axis_tuser_o == OUT_ADDED && m_axis_tdata_o[4:0] != 5'd0)
    else $error("update request without an added neighbor");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

endmodule

bind neighbor_table_with_aging_top nta_chk u_nta_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
